// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by matrix3_inverse.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define M3I_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication after a fixed number of cycles, disabled while reset is low
`define M3I_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

// ----- design/m3i_pkg.sv -----
// ---------------------------------------------------------------------------
// m3i_pkg
// Widths, limits and types shared by the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
package m3i_pkg;

    localparam int ELEM_W    = 32;   // matrix element, signed fixed point
    localparam int COF_W     = 64;   // exact 2x2 cofactor
    localparam int TERM_W    = 96;   // element times cofactor
    localparam int DET_W     = 98;   // exact determinant
    localparam int DMAG_W    = 97;   // determinant magnitude
    localparam int QUO_W     = 32;   // quotient bits kept per lane
    localparam int N_ELEM    = 9;
    localparam int LANE_DM_N = 34;   // divisor taps used inside one lane

    localparam logic [QUO_W:0]    MAG_POS = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W:0]    MAG_NEG = 33'h0_8000_0000;
    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;

    // Clipped value and its clip flag
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              sat;
    } t_res;

    // Determinant result traveling beside the divider lanes
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              sat;
        logic              zero;
    } t_det_res;

endpackage

// ----- design/m3i_front.sv -----
// ---------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline: exact 2x2 cofactors and exact det.
// ---------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; (
    input  logic  i_clk,
    input  t_elem i_a   [N_ELEM],
    output t_cof  o_cof [N_ELEM],
    output t_det  o_det
);

    t_elem r_a    [N_ELEM];
    t_cof  r_pa   [N_ELEM];
    t_cof  r_pb   [N_ELEM];
    t_cof  r_cof3 [N_ELEM];
    t_cof  r_cof4 [N_ELEM];
    t_cof  r_cof5 [N_ELEM];
    t_cof  r_cof6 [N_ELEM];
    t_elem r_a0_2 [3];
    t_elem r_a0_3 [3];
    logic signed [ELEM_W+32:0]  r_lo [3];
    logic signed [COF_W-1:0]    r_hi [3];
    logic signed [TERM_W-1:0]   r_t  [3];
    t_det  r_det;

    // Capture the transferred matrix
    always_ff @(posedge i_clk) begin
        r_a <= i_a;
    end

    // Form the two products of every minor, then the signed cofactor
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int R1 = (r == 0) ? 1 : 0;
            localparam int R2 = (r == 2) ? 1 : 2;
            localparam int C1 = (c == 0) ? 1 : 0;
            localparam int C2 = (c == 2) ? 1 : 2;
            localparam int K  = r * 3 + c;
            always_ff @(posedge i_clk) begin
                r_pa[K] <= COF_W'(r_a[R1*3+C1]) * COF_W'(r_a[R2*3+C2]);
                r_pb[K] <= COF_W'(r_a[R1*3+C2]) * COF_W'(r_a[R2*3+C1]);
                if (((r + c) % 2) == 1) begin
                    r_cof3[K] <= r_pb[K] - r_pa[K];
                end else begin
                    r_cof3[K] <= r_pa[K] - r_pb[K];
                end
            end
        end
    end

    // Expand row 0 against its cofactors in two 32-bit halves
    for (genvar c = 0; c < 3; c++) begin : g_det
        always_ff @(posedge i_clk) begin
            r_a0_2[c] <= r_a[c];
            r_a0_3[c] <= r_a0_2[c];
            r_lo[c]   <= (ELEM_W+33)'(r_a0_3[c]) *
                         (ELEM_W+33)'($signed({1'b0, r_cof3[c][31:0]}));
            r_hi[c]   <= COF_W'(r_a0_3[c]) * COF_W'($signed(r_cof3[c][63:32]));
            r_t[c]    <= $signed({r_hi[c], 32'd0}) + TERM_W'(r_lo[c]);
        end
    end

    // Sum the three terms; delay cofactors alongside
    always_ff @(posedge i_clk) begin
        r_det  <= DET_W'(r_t[0]) + DET_W'(r_t[1]) + DET_W'(r_t[2]);
        r_cof4 <= r_cof3;
        r_cof5 <= r_cof4;
        r_cof6 <= r_cof5;
    end

    assign o_cof = r_cof6;
    assign o_det = r_det;

endmodule

// ----- design/m3i_lane.sv -----
// ---------------------------------------------------------------------------
// m3i_lane
// One divider lane: rounded, saturated cofactor / determinant in fixed point.
// ---------------------------------------------------------------------------
module m3i_lane import m3i_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  t_cof              i_cof,
    input  logic              i_dneg,
    input  logic [DMAG_W-1:0] i_dm [LANE_DM_N],
    output t_res              o_res
);

    localparam int NUM_W = COF_W + 2 * FRAC_BITS;
    localparam int REM_W = (NUM_W > DMAG_W + QUO_W + 1) ? NUM_W : DMAG_W + QUO_W + 1;

    logic [COF_W-1:0] w_mag;
    logic [REM_W-1:0] r_num;
    logic             r_neg_a;
    logic [REM_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             w_rnd;
    logic [QUO_W:0]   w_qr;
    logic             w_neg;
    logic             w_sat;
    t_res             r_res;

    // Scale the cofactor magnitude into the numerator
    assign w_mag = i_cof[COF_W-1] ? (COF_W'(0) - i_cof) : i_cof;

    always_ff @(posedge i_clk) begin
        r_num   <= REM_W'(w_mag) << (2 * FRAC_BITS);
        r_neg_a <= i_cof[COF_W-1] ^ i_dneg;
    end

    // Flag quotients of 2^32 or more up front
    always_ff @(posedge i_clk) begin
        r_rem[0] <= r_num;
        r_q[0]   <= '0;
        r_ovf[0] <= r_num >= (REM_W'(i_dm[0]) << QUO_W);
        r_neg[0] <= r_neg_a;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int B = QUO_W - 1 - j;
        logic [REM_W-1:0] w_dsh;
        logic             w_ge;
        assign w_dsh = REM_W'(i_dm[1+j]) << B;
        assign w_ge  = r_rem[j] >= w_dsh;
        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= w_ge ? (r_rem[j] - w_dsh) : r_rem[j];
            r_q[j+1]   <= {r_q[j][QUO_W-2:0], w_ge};
            r_ovf[j+1] <= r_ovf[j];
            r_neg[j+1] <= r_neg[j];
        end
    end

    // Round half away from zero, then clip to 32 bits
    assign w_rnd = (r_rem[QUO_W] << 1) >= REM_W'(i_dm[LANE_DM_N-1]);
    assign w_qr  = {1'b0, r_q[QUO_W]} + (QUO_W+1)'(w_rnd);
    assign w_neg = r_neg[QUO_W] && (r_ovf[QUO_W] || (w_qr != '0));
    assign w_sat = r_ovf[QUO_W] || (w_neg ? (w_qr > MAG_NEG) : (w_qr > MAG_POS));

    always_ff @(posedge i_clk) begin
        r_res.sat <= w_sat;
        if (w_sat) begin
            r_res.value <= w_neg ? SAT_NEG : SAT_POS;
        end else begin
            r_res.value <= w_neg ? (ELEM_W'(0) - w_qr[ELEM_W-1:0]) : w_qr[ELEM_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/matrix3_inverse.sv -----
// ---------------------------------------------------------------------------
// matrix3_inverse
// Pipelined 3x3 inverse by adjugate over determinant, signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Drive all nine elements and pulse i_start; a transfer takes place on any
//   edge with i_start high and o_busy low. o_busy stays low, so a new matrix
//   may be transferred on every clock.
//   The result appears for one cycle, flagged by o_done: nine inverse
//   elements, the determinant, o_singular (exact determinant zero, then
//   all outputs zero) and o_saturated (any output clipped).
//   Throughput is one matrix per cycle: cofactors and the determinant come
//   from a multiplier pipeline, then nine divider lanes, each retiring one
//   quotient bit per stage over 32 stages, work side by side and a merge
//   stage masks and combines their flags.
//   Reset (i_rst_n low, synchronous) drops every item in flight; o_done
//   stays low until new transfers reach the end.
//   The receiver cannot stall: a result is gone after its o_done cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse import m3i_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_elem i_row0_col0,
    input  t_elem i_row0_col1,
    input  t_elem i_row0_col2,
    input  t_elem i_row1_col0,
    input  t_elem i_row1_col1,
    input  t_elem i_row1_col2,
    input  t_elem i_row2_col0,
    input  t_elem i_row2_col1,
    input  t_elem i_row2_col2,
    output logic  o_done,
    output t_elem o_inv_r0c0,
    output t_elem o_inv_r0c1,
    output t_elem o_inv_r0c2,
    output t_elem o_inv_r1c0,
    output t_elem o_inv_r1c1,
    output t_elem o_inv_r1c2,
    output t_elem o_inv_r2c0,
    output t_elem o_inv_r2c1,
    output t_elem o_inv_r2c2,
    output t_elem o_determinant,
    output logic  o_singular,
    output logic  o_saturated
);

    localparam int LATENCY = 43;
    localparam int DRES_N  = LANE_DM_N + 1;
    localparam logic [DMAG_W:0] HALF = (DMAG_W+1)'(1) << (2 * FRAC_BITS - 1);

    t_elem             w_a [N_ELEM];
    t_cof              w_cof [N_ELEM];
    t_det              w_det;
    logic              w_accept;
    logic              r_vld [LATENCY];
    t_cof              r_cof7 [N_ELEM];
    logic [DMAG_W-1:0] r_dm [DRES_N];
    logic              r_dneg;
    logic              r_dzero;
    logic [DMAG_W-1:0] w_lane_dm [LANE_DM_N];
    t_res              w_res [N_ELEM];
    logic [DMAG_W:0]   w_dsum;
    logic [DMAG_W:0]   w_dshr;
    logic              w_dneg;
    logic              w_dsat;
    t_det_res          r_dres [DRES_N];
    logic              w_lane_sat;
    t_elem             r_inv [N_ELEM];
    t_elem             r_det_out;
    logic              r_sing;
    logic              r_sat;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    assign w_a[0] = i_row0_col0;
    assign w_a[1] = i_row0_col1;
    assign w_a[2] = i_row0_col2;
    assign w_a[3] = i_row1_col0;
    assign w_a[4] = i_row1_col1;
    assign w_a[5] = i_row1_col2;
    assign w_a[6] = i_row2_col0;
    assign w_a[7] = i_row2_col1;
    assign w_a[8] = i_row2_col2;

    m3i_front u_front (
        .i_clk (i_clk),
        .i_a   (w_a),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    // Advance the item marker through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LATENCY; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < LATENCY; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Split the determinant into sign and magnitude; delay the magnitude
    always_ff @(posedge i_clk) begin
        r_cof7  <= w_cof;
        r_dneg  <= w_det[DET_W-1];
        r_dzero <= (w_det == '0);
        r_dm[0] <= DMAG_W'(w_det[DET_W-1] ? (DET_W'(0) - w_det) : w_det);
        for (int k = 1; k < DRES_N; k++) begin
            r_dm[k] <= r_dm[k-1];
        end
    end

    for (genvar k = 0; k < LANE_DM_N; k++) begin : g_dm
        assign w_lane_dm[k] = r_dm[k+1];
    end

    // Nine divider lanes, one per inverse element (transposed cofactor)
    for (genvar i = 0; i < 3; i++) begin : g_lr
        for (genvar j = 0; j < 3; j++) begin : g_lc
            m3i_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_cof  (r_cof7[j*3+i]),
                .i_dneg (r_dneg),
                .i_dm   (w_lane_dm),
                .o_res  (w_res[i*3+j])
            );
        end
    end

    // Round and clip the determinant, then hold it beside the lanes
    assign w_dsum = {1'b0, r_dm[0]} + HALF;
    assign w_dshr = w_dsum >> (2 * FRAC_BITS);
    assign w_dneg = r_dneg && (w_dshr != '0);
    assign w_dsat = w_dneg ? (w_dshr > (DMAG_W+1)'(MAG_NEG))
                           : (w_dshr > (DMAG_W+1)'(MAG_POS));

    always_ff @(posedge i_clk) begin
        r_dres[0].zero <= r_dzero;
        r_dres[0].sat  <= w_dsat;
        if (w_dsat) begin
            r_dres[0].value <= w_dneg ? SAT_NEG : SAT_POS;
        end else begin
            r_dres[0].value <= w_dneg ? (ELEM_W'(0) - w_dshr[ELEM_W-1:0])
                                      : w_dshr[ELEM_W-1:0];
        end
        for (int k = 1; k < DRES_N; k++) begin
            r_dres[k] <= r_dres[k-1];
        end
    end

    // Merge lane flags; a singular matrix drops everything to zero
    always_comb begin
        w_lane_sat = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            w_lane_sat = w_lane_sat | w_res[k].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sing <= r_dres[DRES_N-1].zero;
        if (r_dres[DRES_N-1].zero) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_inv[k] <= '0;
            end
            r_det_out <= '0;
            r_sat     <= 1'b0;
        end else begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_inv[k] <= w_res[k].value;
            end
            r_det_out <= r_dres[DRES_N-1].value;
            r_sat     <= w_lane_sat | r_dres[DRES_N-1].sat;
        end
    end

    assign o_done        = r_vld[LATENCY-1];
    assign o_inv_r0c0    = r_inv[0];
    assign o_inv_r0c1    = r_inv[1];
    assign o_inv_r0c2    = r_inv[2];
    assign o_inv_r1c0    = r_inv[3];
    assign o_inv_r1c1    = r_inv[4];
    assign o_inv_r1c2    = r_inv[5];
    assign o_inv_r2c0    = r_inv[6];
    assign o_inv_r2c1    = r_inv[7];
    assign o_inv_r2c2    = r_inv[8];
    assign o_determinant = r_det_out;
    assign o_singular    = r_sing;
    assign o_saturated   = r_sat;

    // Every transfer comes out after the fixed latency
    `M3I_ASSERT_DELAY(a_latency, i_clk, i_rst_n, w_accept, LATENCY, o_done)
    // A singular result has a zero determinant, r0c0 and r1c1 and is never clipped
    `M3I_ASSERT_IMPL(a_singular_zero, i_clk, i_rst_n, o_done && o_singular,
        (o_determinant == '0) && !o_saturated && (o_inv_r0c0 == '0) && (o_inv_r1c1 == '0))
    // A nonzero determinant output cannot come with the singular flag
    `M3I_ASSERT_IMPL(a_det_nonzero, i_clk, i_rst_n, o_done && (o_determinant != '0),
        !o_singular)

endmodule

// ----- sim/matrix3_inverse_checker.sv -----
// ---------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches the matrix and result channels of matrix3_inverse, predicts each
// inverse from the accepted matrix with exact wide arithmetic, and compares
// every result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module matrix3_inverse_checker import m3i_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_elem i_elem [N_ELEM],
    input  logic  i_done,
    input  t_elem i_inv [N_ELEM],
    input  t_elem i_determinant,
    input  logic  i_singular,
    input  logic  i_saturated,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int FRAC = 16;

    typedef struct {
        t_elem inv [N_ELEM];
        t_elem det;
        logic  singular;
        logic  saturated;
    } t_inverse;

    t_inverse pending_inverses [$];
    int       fail_total = 0;
    int       pend_count = 0;

    // Clip a magnitude with its sign to 32 bits
    function automatic t_elem clip_q(input logic neg, input logic [128:0] mag,
                                     inout logic sat);
        logic [128:0] limit;
        logic [31:0]  v;
        limit = neg ? 129'h8000_0000 : 129'h7FFF_FFFF;
        if (mag > limit) begin
            v   = limit[31:0];
            sat = 1'b1;
        end else begin
            v = mag[31:0];
        end
        if (neg) v = -v;
        return t_elem'(v);
    endfunction

    function automatic t_inverse invert_matrix(input t_elem a [N_ELEM]);
        t_inverse           res;
        logic signed [63:0] cof [3][3];
        logic signed [63:0] m;
        logic signed [129:0] det;
        logic [128:0]       dmag, num, quo, rem;
        logic               dneg, neg, sat;
        int                 r1, r2, c1, c2;
        det = '0;
        sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                // 64-bit wraparound, as the cofactor register holds it
                m = 64'(64'(a[r1*3+c1]) * 64'(a[r2*3+c2]))
                  - 64'(64'(a[r1*3+c2]) * 64'(a[r2*3+c1]));
                cof[r][c] = ((r + c) % 2 == 1) ? -m : m;
            end
        end
        for (int c = 0; c < 3; c++)
            det += 130'(a[c]) * 130'(cof[0][c]);
        if (det == 0) begin
            foreach (res.inv[k]) res.inv[k] = '0;
            res.det       = '0;
            res.singular  = 1'b1;
            res.saturated = 1'b0;
            return res;
        end
        dneg = det < 0;
        dmag = dneg ? 129'(-det) : 129'(det);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m   = cof[c][r];
                num = 129'(m < 0 ? -m : m);
                if (m == 64'sh8000_0000_0000_0000) num = 129'h8000_0000_0000_0000;
                num = num << (2 * FRAC);
                quo = num / dmag;
                rem = num % dmag;
                if ((rem << 1) >= dmag) quo = quo + 1;
                neg = ((m < 0) != dneg) && (quo != 0);
                res.inv[r*3+c] = clip_q(neg, quo, sat);
            end
        end
        dmag = (dmag + (129'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        res.det       = clip_q(dneg && dmag != 0, dmag, sat);
        res.singular  = 1'b0;
        res.saturated = sat;
        return res;
    endfunction

    assign o_fail_count = fail_total;
    assign o_pending    = pend_count;

    // Predict on each matrix transfer, compare on each result strobe
    always @(posedge i_clk) begin
        t_inverse exp_res;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                pending_inverses.push_back(invert_matrix(i_elem));
            if (i_done) begin
                if (pending_inverses.size() == 0) begin
                    $error("unexpected result, nothing pending");
                    fail_total = fail_total + 1;
                end else begin
                    exp_res = pending_inverses.pop_front();
                    for (int k = 0; k < N_ELEM; k++)
                        if (i_inv[k] !== exp_res.inv[k]) begin
                            $error("inv_r%0dc%0d: expected %h actual %h", k / 3, k % 3,
                                   exp_res.inv[k], i_inv[k]);
                            fail_total = fail_total + 1;
                        end
                    if (i_determinant !== exp_res.det) begin
                        $error("determinant: expected %h actual %h", exp_res.det,
                               i_determinant);
                        fail_total = fail_total + 1;
                    end
                    if (i_singular !== exp_res.singular) begin
                        $error("singular: expected %b actual %b", exp_res.singular,
                               i_singular);
                        fail_total = fail_total + 1;
                    end
                    if (i_saturated !== exp_res.saturated) begin
                        $error("saturated: expected %b actual %b", exp_res.saturated,
                               i_saturated);
                        fail_total = fail_total + 1;
                    end
                end
            end
        end
        pend_count = pending_inverses.size();
    end

endmodule

// ----- sim/matrix3_inverse_tb.sv -----
// ---------------------------------------------------------------------------
// matrix3_inverse_tb
// Drives directed and random matrices into matrix3_inverse with varying
// gaps between transfers; the checker predicts and compares each result.
// ---------------------------------------------------------------------------
module matrix3_inverse_tb;
    import m3i_pkg::*;

    localparam int    N_RANDOM   = 1330;
    localparam int    WDOG_LIMIT = 5000;
    localparam t_elem ONE        = 32'sh0001_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_start = 1'b0;
    logic  o_busy, o_done, o_singular, o_saturated;
    t_elem elem [N_ELEM];
    t_elem inv [N_ELEM];
    t_elem o_determinant;
    int    fail_count, pending;
    int    idle_cycles = 0;
    int    gap_pct = 0;
    bit    stim_done = 1'b0;

    always #6 i_clk = ~i_clk;

    matrix3_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_row0_col0(elem[0]), .i_row0_col1(elem[1]), .i_row0_col2(elem[2]),
        .i_row1_col0(elem[3]), .i_row1_col1(elem[4]), .i_row1_col2(elem[5]),
        .i_row2_col0(elem[6]), .i_row2_col1(elem[7]), .i_row2_col2(elem[8]),
        .o_done(o_done),
        .o_inv_r0c0(inv[0]), .o_inv_r0c1(inv[1]), .o_inv_r0c2(inv[2]),
        .o_inv_r1c0(inv[3]), .o_inv_r1c1(inv[4]), .o_inv_r1c2(inv[5]),
        .o_inv_r2c0(inv[6]), .o_inv_r2c1(inv[7]), .o_inv_r2c2(inv[8]),
        .o_determinant(o_determinant), .o_singular(o_singular),
        .o_saturated(o_saturated)
    );

    matrix3_inverse_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_elem(elem), .i_done(o_done), .i_inv(inv), .i_determinant(o_determinant),
        .i_singular(o_singular), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one matrix at a falling edge and hold it until transferred
    task automatic send_matrix(input t_elem m [N_ELEM]);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        foreach (elem[k]) elem[k] <= m[k];
        i_start <= 1'b1;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic send_diag(input t_elem d0, input t_elem d1, input t_elem d2);
        t_elem m [N_ELEM];
        foreach (m[k]) m[k] = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        send_matrix(m);
    endtask

    task automatic send_fill(input t_elem v);
        t_elem m [N_ELEM];
        foreach (m[k]) m[k] = v;
        send_matrix(m);
    endtask

    initial begin
        t_elem m [N_ELEM];
        int    kind;
        foreach (elem[k]) elem[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: identity, scaled, zero, extremes, tiny and huge determinants
        send_diag(ONE, ONE, ONE);
        send_diag(2 * ONE, -4 * ONE, ONE / 2);
        send_diag(-ONE, -ONE, -ONE);
        send_fill('0);
        send_fill(32'sh7FFF_FFFF);
        send_fill(32'sh8000_0000);
        send_diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_diag(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_diag(32'sd1, 32'sd1, 32'sd1);
        send_diag(32'sd1, ONE, ONE);
        send_diag(32'sd256, 32'sd256, 32'sd1);
        send_diag(-32'sd1, 32'sd3, 32'sd7);
        m = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_matrix(m);
        m = '{ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE,
              -ONE, 5 * ONE, ONE};
        send_matrix(m);
        m = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE};
        send_matrix(m);
        m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
        send_matrix(m);
        m = '{ONE, ONE, ONE, ONE, ONE + 1, ONE, ONE, ONE, ONE + 1};
        send_matrix(m);
        m = '{ONE / 4, ONE / 3, -ONE / 5, 7 * ONE, -ONE, 3,
              32'sh0123_4567, -32'sh0765_4321, 32'sh7FFF_0000};
        send_matrix(m);

        // Hold off until the pipeline has drained
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);

        // Random: mostly moderate values that invert cleanly
        for (int n = 0; n < N_RANDOM; n++) begin
            case ((n * 5) / N_RANDOM)
                0: gap_pct = 0;
                1: gap_pct = 62;
                2: gap_pct = 27;
                3: gap_pct = 62;
                default: gap_pct = 0;
            endcase
            kind = $urandom_range(9);
            foreach (m[k]) begin
                case (kind)
                    0, 1: m[k] = t_elem'($urandom);
                    2: m[k] = t_elem'($urandom) >>> $urandom_range(31);
                    3: m[k] = $urandom_range(1) ? t_elem'($urandom_range(3)) : '0;
                    default: m[k] = t_elem'($urandom_range(2 * 8 * ONE)) - 8 * ONE;
                endcase
            end
            // Force a row dependency now and then to hit exact singularity
            if ($urandom_range(15) == 0)
                for (int c = 0; c < 3; c++) m[6 + c] = m[c];
            send_matrix(m);
        end
        i_start <= 1'b0;

        // Drain and let the pipeline settle
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/m3i_pkg.sv
design/m3i_front.sv
design/m3i_lane.sv
design/matrix3_inverse.sv
sim/matrix3_inverse_checker.sv
sim/matrix3_inverse_tb.sv
